@@ rtl/core/gsev_pkg.sv @@
// ----------------------------------------------------------------------------
// gsev_pkg
// Shared types and constants for the grid stencil expectation value block.
// ----------------------------------------------------------------------------
`default_nettype none

package gsev_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRID_DIM     = 2'd0;
    localparam logic [1:0] CFG_ENERGY_COEFF = 2'd1;
    localparam logic [1:0] CFG_INTERVAL     = 2'd2;

    // Quotient selection for the shared divider
    localparam logic [1:0] SEL_ENERGY = 2'd0;
    localparam logic [1:0] SEL_MOMX   = 2'd1;
    localparam logic [1:0] SEL_MOMY   = 2'd2;

    localparam int DVD_W     = 80;
    localparam int DIV_STEPS = 80;
    localparam int SH_ENERGY = 16;
    localparam int SH_MOM    = 15;

    localparam logic [32:0] CAP_POS = 33'h0_7FFF_FFFF;
    localparam logic [32:0] CAP_NEG = 33'h0_8000_0000;

    // Per-frame sums handed from the stencil front to the divider back end
    typedef struct packed {
        logic [31:0] frame_idx;
        logic [63:0] energy_sum;
        logic [63:0] momx_sum;
        logic [63:0] momy_sum;
        logic [47:0] norm_sum;
    } sum_t;

endpackage

`default_nettype wire

@@ rtl/core/grid_stencil_expectation_values_top.sv @@
// ----------------------------------------------------------------------------
// grid_stencil_expectation_values_top
// Five-point stencil energy and momentum expectation values over a streamed
// complex wavefunction grid, one result per frame.
// ----------------------------------------------------------------------------
//
// Channel   Handshake           Payload
// input     push / full         psi_re, psi_im, potential
// result    pop / empty         snapshot_time, energy, momentum_x, momentum_y,
//                               momentum_sq, norm, zero_norm
// config    cfg_we              cfg_index, cfg_data
//
// Each grid point passes through the front in order: line buffer read, two
// multiply stages and the accumulate. A frame's result is computed by three
// 80-step serial divisions in the back end; this overlaps with the next
// frame's points. Reset clears counters and sums; the line buffers need no
// clearing. Full stays high while the front is busy with a point; beyond
// that the input stalls only when two frame records wait for the divider.
// The result register holds until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_stencil_expectation_values_top #(
    parameter int GRID_MAX = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] psi_re,
    input  wire logic signed [15:0] psi_im,
    input  wire logic signed [15:0] potential,
    output logic                    empty,
    input  wire logic               pop,
    output logic [31:0]             snapshot_time,
    output logic signed [31:0]      energy,
    output logic signed [31:0]      momentum_x,
    output logic signed [31:0]      momentum_y,
    output logic [31:0]             momentum_sq,
    output logic [47:0]             norm,
    output logic                    zero_norm,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);
    import gsev_pkg::*;

    logic [8:0]         grid_dim_reg;
    logic signed [23:0] energy_coeff_reg;
    logic [15:0]        interval_reg;

    logic q_full, q_push, q_empty, q_pop;
    sum_t q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_dim_reg     <= 9'd256;
            energy_coeff_reg <= -24'sd32768;
            interval_reg     <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_DIM:     grid_dim_reg     <= cfg_data[8:0];
                CFG_ENERGY_COEFF: energy_coeff_reg <= cfg_data;
                CFG_INTERVAL:     interval_reg     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    gsev_front #(
        .GRID_MAX(GRID_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .psi_re       (psi_re),
        .psi_im       (psi_im),
        .potential    (potential),
        .grid_dim     (grid_dim_reg),
        .energy_coeff (energy_coeff_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    gsev_sum_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    gsev_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_data            (q_rdata),
        .q_pop             (q_pop),
        .snapshot_interval (interval_reg),
        .empty             (empty),
        .pop               (pop),
        .snapshot_time     (snapshot_time),
        .energy            (energy),
        .momentum_x        (momentum_x),
        .momentum_y        (momentum_y),
        .momentum_sq       (momentum_sq),
        .norm              (norm),
        .zero_norm         (zero_norm)
    );

endmodule

`default_nettype wire

@@ rtl/core/gsev_front.sv @@
// ----------------------------------------------------------------------------
// gsev_front
// Accepts grid points, keeps two line buffers plus a potential row and
// accumulates the stencil sums; pushes one sum record per completed frame.
// ----------------------------------------------------------------------------
`default_nettype none

module gsev_front #(
    parameter int GRID_MAX = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] psi_re,
    input  wire logic signed [15:0] psi_im,
    input  wire logic signed [15:0] potential,
    input  wire logic        [8:0]  grid_dim,
    input  wire logic signed [23:0] energy_coeff,
    input  wire logic               q_full,
    output logic                    q_push,
    output gsev_pkg::sum_t          q_data
);
    import gsev_pkg::*;

    localparam int AW  = $clog2(GRID_MAX);
    localparam int DW0 = $clog2(GRID_MAX + 1);
    localparam int CW  = (DW0 > 9) ? DW0 : 9;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_RD   = 3'd1;
    localparam logic [2:0] F_M1   = 3'd2;
    localparam logic [2:0] F_M2   = 3'd3;
    localparam logic [2:0] F_M3   = 3'd4;

    logic [2:0] state_reg;

    logic [31:0] row_older     [GRID_MAX];
    logic [31:0] row_newer     [GRID_MAX];
    logic [15:0] potential_row [GRID_MAX];

    logic [AW-1:0] col_reg, row_reg;
    logic [31:0]   frame_reg;
    logic [63:0]   energy_sum_reg, momx_sum_reg, momy_sum_reg;
    logic [47:0]   norm_sum_reg;

    logic signed [15:0] pr_reg, pi_reg, v_reg;
    logic               interior_reg;
    logic [31:0]        up_reg, ce_reg, rt_reg, lf_reg;
    logic [15:0]        vc_reg;

    logic signed [34:0] p_clr_reg, p_cli_reg;
    logic signed [31:0] p_mr_reg, p_mi_reg;
    logic signed [32:0] mxa_reg, mxb_reg, mya_reg, myb_reg;
    logic signed [59:0] e1_reg;
    logic signed [48:0] e2_reg;
    logic signed [33:0] mx_reg, my_reg;
    logic        [31:0] mag2_reg;

    logic [CW-1:0] g_ext, d_eff, col_ext, row_ext;
    logic          accept, col_last, row_last, interior;
    logic [AW-1:0] col_p1;

    logic signed [15:0] ur, ui, cr, ci, lr, li, rr, ri;
    logic signed [18:0] lapr, lapi;
    logic signed [16:0] dxi, dxr, dyi, dyr;
    logic signed [35:0] dot;
    logic signed [32:0] mag2;
    logic signed [63:0] e_term, mx_ext, my_ext;
    logic [63:0]        energy_sum_next, momx_sum_next, momy_sum_next;
    logic [47:0]        norm_sum_next;

    always_comb
    begin
        g_ext = CW'(grid_dim);
        d_eff = g_ext;
        if (g_ext < CW'(3))
            d_eff = CW'(3);
        if (g_ext > CW'(GRID_MAX))
            d_eff = CW'(GRID_MAX);
        col_ext  = CW'(col_reg);
        row_ext  = CW'(row_reg);
        col_p1   = col_reg + AW'(1);
        col_last = !((col_ext + CW'(1)) < d_eff);
        row_last = !((row_ext + CW'(1)) < d_eff);
        interior = (row_ext >= CW'(2)) && (col_ext >= CW'(1)) && !col_last;
    end

    assign full   = (state_reg != F_IDLE) || q_full;
    assign accept = push && !full;

    // Line buffers: registered reads at the item's column, one write per item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg <= row_older[col_reg];
            ce_reg <= row_newer[col_reg];
            rt_reg <= row_newer[col_p1];
            vc_reg <= potential_row[col_reg];
        end
        if (state_reg == F_RD)
        begin
            row_older[col_reg]     <= ce_reg;
            row_newer[col_reg]     <= {pi_reg, pr_reg};
            potential_row[col_reg] <= v_reg;
        end
    end

    always_comb
    begin
        ur   = up_reg[15:0];
        ui   = up_reg[31:16];
        cr   = ce_reg[15:0];
        ci   = ce_reg[31:16];
        lr   = lf_reg[15:0];
        li   = lf_reg[31:16];
        rr   = rt_reg[15:0];
        ri   = rt_reg[31:16];
        lapr = 19'(ur) + 19'(pr_reg) + 19'(lr) + 19'(rr) - (19'(cr) <<< 2);
        lapi = 19'(ui) + 19'(pi_reg) + 19'(li) + 19'(ri) - (19'(ci) <<< 2);
        dxi  = 17'(ri) - 17'(li);
        dxr  = 17'(rr) - 17'(lr);
        dyi  = 17'(pi_reg) - 17'(ui);
        dyr  = 17'(pr_reg) - 17'(ur);
        dot  = 36'(p_clr_reg) + 36'(p_cli_reg);
        mag2 = 33'(p_mr_reg) + 33'(p_mi_reg);
        e_term = 64'(e1_reg >>> 16) + 64'(e2_reg >>> 8);
        mx_ext = 64'(mx_reg);
        my_ext = 64'(my_reg);
        energy_sum_next = energy_sum_reg;
        momx_sum_next   = momx_sum_reg;
        momy_sum_next   = momy_sum_reg;
        norm_sum_next   = norm_sum_reg;
        if (interior_reg)
        begin
            energy_sum_next = energy_sum_reg + e_term;
            momx_sum_next   = momx_sum_reg + mx_ext;
            momy_sum_next   = momy_sum_reg + my_ext;
            norm_sum_next   = norm_sum_reg + 48'(mag2_reg);
        end
    end

    // Datapath registers: products, then second multiply, then accumulate.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pr_reg <= psi_re;
            pi_reg <= psi_im;
            v_reg  <= potential;
        end
        if (state_reg == F_M1)
        begin
            p_clr_reg <= 35'(cr) * 35'(lapr);
            p_cli_reg <= 35'(ci) * 35'(lapi);
            p_mr_reg  <= 32'(cr) * 32'(cr);
            p_mi_reg  <= 32'(ci) * 32'(ci);
            mxa_reg   <= 33'(cr) * 33'(dxi);
            mxb_reg   <= 33'(ci) * 33'(dxr);
            mya_reg   <= 33'(cr) * 33'(dyi);
            myb_reg   <= 33'(ci) * 33'(dyr);
        end
        if (state_reg == F_M2)
        begin
            e1_reg   <= 60'(dot) * 60'(energy_coeff);
            e2_reg   <= 49'($signed(vc_reg)) * 49'(mag2);
            mag2_reg <= mag2[31:0];
            mx_reg   <= 34'(mxa_reg) - 34'(mxb_reg);
            my_reg   <= 34'(mya_reg) - 34'(myb_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            frame_reg      <= '0;
            energy_sum_reg <= '0;
            momx_sum_reg   <= '0;
            momy_sum_reg   <= '0;
            norm_sum_reg   <= '0;
            interior_reg   <= 1'b0;
            lf_reg         <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        interior_reg <= interior;
                        state_reg    <= F_RD;
                    end
                end
                F_RD: state_reg <= F_M1;
                F_M1: state_reg <= F_M2;
                F_M2: state_reg <= F_M3;
                F_M3:
                begin
                    state_reg <= F_IDLE;
                    // The next column's left neighbor is this column's center.
                    lf_reg    <= ce_reg;
                    if (!col_last)
                    begin
                        col_reg <= col_p1;
                    end
                    else
                    begin
                        col_reg <= '0;
                        if (!row_last)
                            row_reg <= row_reg + AW'(1);
                        else
                            row_reg <= '0;
                    end
                    if (col_last && row_last)
                    begin
                        frame_reg      <= frame_reg + 32'd1;
                        energy_sum_reg <= '0;
                        momx_sum_reg   <= '0;
                        momy_sum_reg   <= '0;
                        norm_sum_reg   <= '0;
                    end
                    else
                    begin
                        energy_sum_reg <= energy_sum_next;
                        momx_sum_reg   <= momx_sum_next;
                        momy_sum_reg   <= momy_sum_next;
                        norm_sum_reg   <= norm_sum_next;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign q_push = (state_reg == F_M3) && col_last && row_last;

    always_comb
    begin
        q_data.frame_idx  = frame_reg;
        q_data.energy_sum = energy_sum_next;
        q_data.momx_sum   = momx_sum_next;
        q_data.momy_sum   = momy_sum_next;
        q_data.norm_sum   = norm_sum_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/gsev_sum_queue.sv @@
// ----------------------------------------------------------------------------
// gsev_sum_queue
// Two-entry queue of per-frame sum records between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gsev_sum_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire gsev_pkg::sum_t wr_data,
    output logic                q_full,
    input  wire logic           rd_en,
    output gsev_pkg::sum_t      rd_data,
    output logic                q_empty
);
    import gsev_pkg::*;

    sum_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= !wptr_reg;
            if (do_rd)
                rptr_reg <= !rptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/gsev_back.sv @@
// ----------------------------------------------------------------------------
// gsev_back
// Turns one frame's sums into a result: three saturated quotients from a
// shared bit-serial divider, the squared momentum and the time label.
// ----------------------------------------------------------------------------
`default_nettype none

module gsev_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire gsev_pkg::sum_t q_data,
    output logic                q_pop,
    input  wire logic [15:0]    snapshot_interval,
    output logic                empty,
    input  wire logic           pop,
    output logic [31:0]         snapshot_time,
    output logic signed [31:0]  energy,
    output logic signed [31:0]  momentum_x,
    output logic signed [31:0]  momentum_y,
    output logic [31:0]         momentum_sq,
    output logic [47:0]         norm,
    output logic                zero_norm
);
    import gsev_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_LOAD = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_SQX  = 3'd3;
    localparam logic [2:0] B_SQY  = 3'd4;
    localparam logic [2:0] B_DONE = 3'd5;

    logic [2:0]       state_reg;
    sum_t             sum_reg;
    logic [1:0]       sel_reg;
    logic [6:0]       cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [47:0]      rem_reg;
    logic [32:0]      q_reg;
    logic             ovf_reg, neg_reg, zero_reg;
    logic [31:0]      qe_reg, qx_reg, qy_reg;
    logic [63:0]      sq_reg;
    logic             out_valid_reg;

    logic [63:0]      num_sel, mag_sel;
    logic [DVD_W-1:0] dvd_init;
    logic [1:0]       sel_init;
    logic [48:0]      rem_s;
    logic             qbit;
    logic [47:0]      rem_next;
    logic [32:0]      q_next, cap;
    logic             ovf_next, sat;
    logic [31:0]      res_mag, res;
    logic [64:0]      sq_sum;
    logic             out_free;

    assign out_free = !out_valid_reg;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty && out_free;
    assign empty    = !out_valid_reg;

    // Operand setup for the quotient that comes next.
    always_comb
    begin
        sel_init = (state_reg == B_LOAD) ? SEL_ENERGY : (sel_reg + 2'd1);
        case (sel_init)
            SEL_ENERGY: num_sel = sum_reg.energy_sum;
            SEL_MOMX:   num_sel = sum_reg.momx_sum;
            default:    num_sel = sum_reg.momy_sum;
        endcase
        mag_sel = num_sel[63] ? (~num_sel + 64'd1) : num_sel;
        if (sel_init == SEL_ENERGY)
            dvd_init = DVD_W'(mag_sel) << SH_ENERGY;
        else
            dvd_init = DVD_W'(mag_sel) << SH_MOM;
    end

    // One restoring division step per cycle.
    always_comb
    begin
        rem_s    = {rem_reg, dvd_reg[DVD_W-1]};
        qbit     = (rem_s >= {1'b0, sum_reg.norm_sum});
        rem_next = qbit ? 48'(rem_s - {1'b0, sum_reg.norm_sum}) : rem_s[47:0];
        q_next   = {q_reg[31:0], qbit};
        ovf_next = ovf_reg || q_reg[32];
        cap      = neg_reg ? CAP_NEG : CAP_POS;
        sat      = ovf_next || (q_next > cap);
        res_mag  = sat ? cap[31:0] : q_next[31:0];
        res      = neg_reg ? (~res_mag + 32'd1) : res_mag;
        sq_sum   = {1'b0, sq_reg} + 65'($signed(qy_reg) * $signed(qy_reg));
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            sum_reg <= q_data;
        unique case (state_reg)
            B_LOAD, B_DIV:
            begin
                if (state_reg == B_LOAD || cnt_reg == 7'(DIV_STEPS - 1))
                begin
                    dvd_reg <= dvd_init;
                    rem_reg <= '0;
                    q_reg   <= '0;
                    ovf_reg <= 1'b0;
                    neg_reg <= num_sel[63];
                    cnt_reg <= '0;
                    sel_reg <= sel_init;
                end
                else
                begin
                    dvd_reg <= dvd_reg << 1;
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    ovf_reg <= ovf_next;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                if (state_reg == B_DIV && cnt_reg == 7'(DIV_STEPS - 1))
                begin
                    case (sel_reg)
                        SEL_ENERGY: qe_reg <= res;
                        SEL_MOMX:   qx_reg <= res;
                        default:    qy_reg <= res;
                    endcase
                end
            end
            B_SQX: sq_reg <= 64'($signed(qx_reg) * $signed(qx_reg));
            B_SQY: sq_reg <= sq_sum[63:0];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            zero_reg      <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                        state_reg <= B_LOAD;
                end
                B_LOAD:
                begin
                    zero_reg  <= (sum_reg.norm_sum == 48'd0);
                    state_reg <= (sum_reg.norm_sum == 48'd0) ? B_DONE : B_DIV;
                end
                B_DIV:
                begin
                    if (cnt_reg == 7'(DIV_STEPS - 1) && sel_reg == SEL_MOMY)
                        state_reg <= B_SQX;
                end
                B_SQX: state_reg <= B_SQY;
                B_SQY: state_reg <= B_DONE;
                B_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Result register, loaded once per frame.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_DONE)
        begin
            snapshot_time <= 32'(sum_reg.frame_idx * 32'(snapshot_interval));
            norm          <= sum_reg.norm_sum;
            zero_norm     <= zero_reg;
            if (zero_reg)
            begin
                energy      <= '0;
                momentum_x  <= '0;
                momentum_y  <= '0;
                momentum_sq <= '0;
            end
            else
            begin
                energy      <= qe_reg;
                momentum_x  <= qx_reg;
                momentum_y  <= qy_reg;
                momentum_sq <= (sq_reg[63:48] != 16'd0) ? 32'hFFFF_FFFF : sq_reg[47:16];
            end
        end
    end

endmodule

`default_nettype wire
